// File: sv/wsw_pkg.sv
// Package: sizes, derived widths and sequencer states of the working-set window tracker.
`default_nettype none

package wsw_pkg;

    localparam int WINDOW    = 5;
    localparam int PAGE_BITS = 16;

    // Slot index width and result count width (count runs 0..WINDOW)
    localparam int PTR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W = $clog2(WINDOW + 1);

    typedef logic [PAGE_BITS-1:0] page_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_EMIT
    } state_t;

endpackage

`default_nettype wire

// File: sv/wsw_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none

module wsw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8
) (
    input  wire logic                                     clk,
    input  wire logic                                     we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                         wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: sv/working_set_window_tracker_top.sv
// Top level: working-set window tracker with window RAM, valid bits and walk sequencer.
//
// Usage
//   Input channel (page, in_valid, in_ready): one request is one page reference.
//   in_ready is high only while the block is idle; one request is held at a time.
//   Output channel (ws_page, last, out_valid, out_ready): for each request the
//   block returns every distinct valid page of the window, oldest slot first,
//   then newest to older; last marks the final result of the request.
//   Timing: the accept edge writes the page into the window RAM. The walk then
//   reads one slot per cycle from the RAM (one read port, registered read data)
//   and visits every slot of the window. Results leave as soon as a following
//   distinct page or the end of the walk is known; the final result is offered
//   only after the walk has ended. A new request is taken only once the final
//   result of the last one has been taken, a pace set by the single RAM read
//   port and the end-of-walk step.
//   Stall: if out_ready is low the current result holds with its payload steady;
//   the walk carries on into the held-result list and the block waits.
//   Reset (rst_n low, asynchronous): all slots become unused, the write pointer
//   returns to slot zero and the sequencer idles. RAM contents are not cleared:
//   the per-slot valid bits mask them.
`default_nettype none

module working_set_window_tracker_top
    import wsw_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic [15:0] page,
    input  wire logic        in_valid,
    output logic             in_ready,
    output logic      [15:0] ws_page,
    output logic             last,
    output logic             out_valid,
    input  wire logic        out_ready
);

    state_t              state_reg, state_next;
    logic [PTR_W-1:0]    wptr_reg, wptr_next;
    logic [WINDOW-1:0]   valid_reg, valid_next;
    logic [PTR_W-1:0]    rd_slot_reg, rd_slot_next;
    logic [CNT_W-1:0]    issue_cnt_reg, issue_cnt_next;
    logic                chk_reg, chk_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CNT_W-1:0]    emit_idx_reg, emit_idx_next;
    page_t               seen_reg [WINDOW];

    page_t               ram_rdata;
    page_t               page_st;
    logic                in_fire;
    logic                out_fire;
    logic                issuing;
    logic                dup;
    logic                append;
    logic                last_int;
    logic                walk_end;

    assign page_st  = PAGE_BITS'(page);
    assign in_fire  = in_valid && in_ready;
    assign out_fire = out_valid && out_ready;
    assign issuing  = (state_reg == ST_WALK) && (issue_cnt_reg < CNT_W'(WINDOW));
    assign walk_end = (state_reg == ST_WALK) && (issue_cnt_reg == CNT_W'(WINDOW)) && !chk_reg;

    // Window RAM: written on acceptance, read one slot per walk cycle
    wsw_ram #(
        .WIDTH (PAGE_BITS),
        .DEPTH (WINDOW)
    ) u_window_ram (
        .clk   (clk),
        .we    (in_fire),
        .waddr (wptr_reg),
        .wdata (page_st),
        .raddr (rd_slot_reg),
        .rdata (ram_rdata)
    );

    // Compare the returned page against every page already kept for this request
    always_comb
    begin
        dup = 1'b0;
        for (int j = 0; j < WINDOW; j++)
        begin
            if ((CNT_W'(j) < count_reg) && (seen_reg[j] == ram_rdata))
            begin
                dup = 1'b1;
            end
        end
    end

    assign append = chk_reg && !dup;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (walk_end)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_fire && last_int)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer
    always_comb
    begin
        in_ready  = 1'b0;
        out_valid = 1'b0;
        last_int  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            ST_WALK:
            begin
                // Release a result only once a later distinct page proves it is not last
                out_valid = (emit_idx_reg + CNT_W'(1)) < count_reg;
            end
            ST_EMIT:
            begin
                out_valid = emit_idx_reg < count_reg;
                last_int  = (emit_idx_reg + CNT_W'(1)) == count_reg;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    assign last    = last_int;
    assign ws_page = 16'(seen_reg[emit_idx_reg[PTR_W-1:0]]);

    // Datapath next values
    always_comb
    begin
        wptr_next      = wptr_reg;
        valid_next     = valid_reg;
        rd_slot_next   = rd_slot_reg;
        issue_cnt_next = issue_cnt_reg;
        chk_next       = 1'b0;
        count_next     = count_reg;
        emit_idx_next  = emit_idx_reg;

        if (in_fire)
        begin
            // Mark the slot, move the pointer back and start the walk there
            valid_next[wptr_reg] = 1'b1;
            wptr_next      = (wptr_reg == '0) ? PTR_W'(WINDOW - 1) : wptr_reg - PTR_W'(1);
            rd_slot_next   = wptr_next;
            issue_cnt_next = '0;
            count_next     = '0;
            emit_idx_next  = '0;
        end
        else
        begin
            if (issuing)
            begin
                chk_next       = valid_reg[rd_slot_reg];
                issue_cnt_next = issue_cnt_reg + CNT_W'(1);
                rd_slot_next   = (rd_slot_reg == PTR_W'(WINDOW - 1)) ? '0
                                                                   : rd_slot_reg + PTR_W'(1);
            end
            if (append)
            begin
                count_next = count_reg + CNT_W'(1);
            end
            if (out_fire)
            begin
                emit_idx_next = emit_idx_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wptr_reg      <= '0;
            valid_reg     <= '0;
            rd_slot_reg   <= '0;
            issue_cnt_reg <= '0;
            chk_reg       <= 1'b0;
            count_reg     <= '0;
            emit_idx_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            wptr_reg      <= wptr_next;
            valid_reg     <= valid_next;
            rd_slot_reg   <= rd_slot_next;
            issue_cnt_reg <= issue_cnt_next;
            chk_reg       <= chk_next;
            count_reg     <= count_next;
            emit_idx_reg  <= emit_idx_next;
        end
    end

    // Held-result list: append each new distinct page
    always_ff @(posedge clk)
    begin
        if (append)
        begin
            seen_reg[count_reg[PTR_W-1:0]] <= ram_rdata;
        end
    end

    // Never offer a result while taking a new request
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("result offered while idle");

    // The final result hands control back to the input side
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && last) |=> in_ready)
        else $error("block not idle after final result");

    // An accepted request leaves its slot valid and starts the walk
    a_slot_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (valid_reg[$past(wptr_reg)] && state_reg == ST_WALK))
        else $error("written slot not marked valid");

    // Emission never overtakes the held-result list, which never overflows
    a_emit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (emit_idx_reg <= count_reg) && (count_reg <= CNT_W'(WINDOW)))
        else $error("result index out of range");

    // The walk always finds at least the page just written
    a_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (count_reg != '0))
        else $error("walk ended with no result");

endmodule

`default_nettype wire
